// ===== src/afs_pkg.sv =====
// ----------------------------------------------------------------------------
// afs_pkg
// Shared types and constants for the animation frame sequencer.
// ----------------------------------------------------------------------------
package afs_pkg;

   localparam int MAX_FRAMES = 64;

   localparam int IDX_W   = (MAX_FRAMES > 2) ? $clog2(MAX_FRAMES) : 1;
   localparam int N_W     = $clog2(MAX_FRAMES + 1);
   localparam int DUR_W   = 16;
   localparam int TOTAL_W = DUR_W + IDX_W;
   localparam int OFF_W   = 17;
   localparam int POS_W   = 32;
   localparam int ALU_W   = TOTAL_W + 2;
   localparam int CNT_W   = (N_W > 6) ? N_W : 6;

   localparam int FC_W    = 7;
   localparam int TICK_W  = 10;
   localparam int SLOT_W  = 6;
   localparam int RAW_W   = 16;
   localparam int FRAME_W = 6;

   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TICK_LENGTH = 1'd1;

   localparam logic [TICK_W-1:0] TICK_RESET   = 10'd20;
   localparam logic [RAW_W-1:0]  SHORT_DELAY  = 16'd10;
   localparam logic [RAW_W-1:0]  DEFAULT_DLY  = 16'd100;
   localparam logic [RAW_W-1:0]  MIN_DELAY    = 16'd20;
   localparam logic [OFF_W-1:0]  START_CAP    = 17'd60000;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_TICK  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef struct packed {
      logic             sub;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] res;
      logic             carry;
   } alu_rsp_type;

endpackage

// ===== src/afs_alu.sv =====
// ----------------------------------------------------------------------------
// afs_alu
// Shared add/subtract unit; carry out doubles as borrow on subtract.
// ----------------------------------------------------------------------------
module afs_alu (
   input  afs_pkg::alu_req_type alu_req,
   output afs_pkg::alu_rsp_type alu_rsp
);
   import afs_pkg::*;

   logic [ALU_W:0] full;

   always_comb begin
      if (alu_req.sub) begin
         full = {1'b0, alu_req.a} - {1'b0, alu_req.b};
      end else begin
         full = {1'b0, alu_req.a} + {1'b0, alu_req.b};
      end
      alu_rsp.res   = full[ALU_W-1:0];
      alu_rsp.carry = full[ALU_W];
   end

endmodule

// ===== src/animation_frame_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// animation_frame_sequencer_unit
// Selects the displayed frame of an animated image and the time into it.
// ----------------------------------------------------------------------------
// One transaction in, one out. Load and no-op items, and start or tick items
// with one frame or fewer, go straight to the result. With n frames active,
// a tick sums the n durations, reduces the offset by a division when it
// passes the whole cycle length and walks the frames stepped over; a start
// divides the position by the cycle length before the walk. An index left
// beyond a reduced frame count is brought below n by taking n off it. The
// single shared adder does the duration sum, the bit-per-cycle remainder
// and the frame walk; the delay memory has one read port. The input is
// not ready while an item is in progress or its result is still waiting.
// ----------------------------------------------------------------------------
module animation_frame_sequencer_unit (
   input  logic                              clock,
   input  logic                              reset,
   // frame_slot[5:0], raw_delay[21:6], timer_position[53:22]
   input  logic [afs_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op[1:0]
   input  logic [afs_pkg::REQ_USER_W-1:0]    req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // shown_frame[5:0], frame_offset[22:6], animating[23]
   output logic [afs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [afs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [afs_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import afs_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b0000000001,
      ST_SUM      = 10'b0000000010,
      ST_PREP     = 10'b0000000100,
      ST_DIV      = 10'b0000001000,
      ST_CLAMP    = 10'b0000010000,
      ST_IDXMOD   = 10'b0000100000,
      ST_CHK      = 10'b0001000000,
      ST_REDFIN   = 10'b0010000000,
      ST_WALK_RD  = 10'b0100000000,
      ST_WALK_CMP = 10'b1000000000
   } state_type;

   localparam state_type ST_FINISH = ST_IDLE;

   state_type          state_ff, state_in;
   logic               finish_ff, finish_in;
   logic [FC_W-1:0]    frame_count_ff, frame_count_in;
   logic [TICK_W-1:0]  tick_len_ff, tick_len_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic               start_ff, start_in;
   logic               red_ff, red_in;
   logic [POS_W-1:0]   dvd_ff, dvd_in;
   logic [TOTAL_W-1:0] rem_ff, rem_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic [OFF_W-1:0]   rsp_off_ff, rsp_off_in;
   logic               rsp_anim_ff, rsp_anim_in;

   logic [DUR_W-1:0]   dur_mem [MAX_FRAMES];
   logic [DUR_W-1:0]   rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               mem_we;
   logic [IDX_W-1:0]   wr_addr;
   logic [DUR_W-1:0]   wr_data;

   alu_req_type        alu_req;
   alu_rsp_type        alu_rsp;

   op_type             req_op;
   logic [SLOT_W-1:0]  req_slot;
   logic [RAW_W-1:0]   req_raw;
   logic [POS_W-1:0]   req_pos;
   logic [RAW_W-1:0]   dly_a;
   logic [N_W-1:0]     n_act;
   logic               animate;
   logic [N_W-1:0]     idx_next;

   afs_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign req_op   = op_type'(req_tuser);
   assign req_slot = req_tdata[5:0];
   assign req_raw  = req_tdata[21:6];
   assign req_pos  = req_tdata[53:22];

   assign req_tready = (state_ff == ST_IDLE) && !finish_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_anim_ff, rsp_off_ff, rsp_frame_ff};

   always_comb begin
      if (32'(frame_count_ff) > MAX_FRAMES) begin
         n_act = N_W'(MAX_FRAMES);
      end else begin
         n_act = N_W'(frame_count_ff);
      end
      animate  = (frame_count_ff > FC_W'(1));
      idx_next = N_W'(idx_ff) + N_W'(1);
      dly_a    = (req_raw <= SHORT_DELAY) ? DEFAULT_DLY : req_raw;
   end

   always_comb begin
      state_in       = state_ff;
      finish_in      = finish_ff;
      frame_count_in = frame_count_ff;
      tick_len_in    = tick_len_ff;
      total_in       = total_ff;
      idx_in         = idx_ff;
      off_in         = off_ff;
      cnt_in         = cnt_ff;
      pend_in        = pend_ff;
      start_in       = start_ff;
      red_in         = red_ff;
      dvd_in         = dvd_ff;
      rem_in         = rem_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_frame_in   = rsp_frame_ff;
      rsp_off_in     = rsp_off_ff;
      rsp_anim_in    = rsp_anim_ff;
      mem_we         = 1'b0;
      wr_addr        = IDX_W'(req_slot);
      wr_data        = (dly_a < MIN_DELAY) ? MIN_DELAY : dly_a;
      rd_addr        = idx_ff;
      alu_req.sub    = 1'b1;
      alu_req.a      = '0;
      alu_req.b      = '0;

      if (csr_we) begin
         case (csr_index)
            REG_FRAME_COUNT: frame_count_in = csr_wdata[FC_W-1:0];
            REG_TICK_LENGTH: tick_len_in    = csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (finish_ff) begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_in = 1'b1;
                  rsp_frame_in = FRAME_W'(idx_ff);
                  rsp_off_in   = off_ff;
                  rsp_anim_in  = animate;
                  finish_in    = 1'b0;
               end
            end else if (req_tvalid) begin
               finish_in = 1'b1;
               total_in  = total_ff;
               cnt_in    = '0;
               pend_in   = 1'b0;
               dvd_in    = req_pos;
               case (req_op)
                  OP_LOAD: begin
                     mem_we = (32'(req_slot) < MAX_FRAMES);
                  end
                  OP_START: begin
                     idx_in = '0;
                     if (n_act > N_W'(1)) begin
                        total_in  = '0;
                        start_in  = 1'b1;
                        finish_in = 1'b0;
                        state_in  = ST_SUM;
                     end else begin
                        off_in = '0;
                     end
                  end
                  OP_TICK: begin
                     if (n_act > N_W'(1)) begin
                        off_in    = off_ff + OFF_W'(tick_len_ff);
                        total_in  = '0;
                        start_in  = 1'b0;
                        finish_in = 1'b0;
                        state_in  = ST_SUM;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SUM: begin
            rd_addr   = IDX_W'(cnt_ff);
            alu_req.sub = 1'b0;
            alu_req.a = ALU_W'(total_ff);
            alu_req.b = ALU_W'(rd_data_ff);
            if (pend_ff) begin
               total_in = alu_rsp.res[TOTAL_W-1:0];
            end
            if (cnt_ff < CNT_W'(n_act)) begin
               cnt_in  = cnt_ff + CNT_W'(1);
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (total_ff == '0) begin
               off_in   = '0;
               state_in = ST_IDXMOD;
            end else if (start_ff) begin
               rem_in   = '0;
               cnt_in   = '0;
               red_in   = 1'b0;
               state_in = ST_DIV;
            end else begin
               state_in = ST_IDXMOD;
            end
         end
         ST_DIV: begin
            alu_req.a = ALU_W'({rem_ff, dvd_ff[POS_W-1]});
            alu_req.b = ALU_W'(total_ff);
            if (alu_rsp.carry) begin
               rem_in = alu_req.a[TOTAL_W-1:0];
            end else begin
               rem_in = alu_rsp.res[TOTAL_W-1:0];
            end
            dvd_in = {dvd_ff[POS_W-2:0], 1'b0};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(POS_W - 1)) begin
               state_in = red_ff ? ST_REDFIN : ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            alu_req.a = ALU_W'(rem_ff);
            alu_req.b = ALU_W'(START_CAP);
            off_in    = alu_rsp.carry ? OFF_W'(rem_ff) : START_CAP;
            state_in  = ST_IDXMOD;
         end
         ST_IDXMOD: begin
            alu_req.a = ALU_W'(idx_ff);
            alu_req.b = ALU_W'(n_act);
            if (!alu_rsp.carry) begin
               idx_in = IDX_W'(alu_rsp.res);
            end else begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            alu_req.a = ALU_W'(total_ff);
            alu_req.b = ALU_W'(off_ff);
            if (alu_rsp.carry) begin
               dvd_in   = POS_W'(off_ff - OFF_W'(1));
               rem_in   = '0;
               cnt_in   = '0;
               red_in   = 1'b1;
               state_in = ST_DIV;
            end else begin
               state_in = ST_WALK_RD;
            end
         end
         ST_REDFIN: begin
            off_in   = OFF_W'(rem_ff + TOTAL_W'(1));
            state_in = ST_WALK_RD;
         end
         ST_WALK_RD: begin
            state_in = ST_WALK_CMP;
         end
         ST_WALK_CMP: begin
            alu_req.a = ALU_W'(off_ff);
            alu_req.b = ALU_W'(rd_data_ff);
            if (!alu_rsp.carry && (alu_rsp.res != '0)) begin
               off_in   = OFF_W'(alu_rsp.res);
               idx_in   = (idx_next == n_act) ? '0 : IDX_W'(idx_next);
               state_in = ST_WALK_RD;
            end else begin
               finish_in = 1'b1;
               state_in  = ST_FINISH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         finish_ff      <= 1'b0;
         frame_count_ff <= '0;
         tick_len_ff    <= TICK_RESET;
         total_ff       <= '0;
         idx_ff         <= '0;
         off_ff         <= '0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         finish_ff      <= finish_in;
         frame_count_ff <= frame_count_in;
         tick_len_ff    <= tick_len_in;
         total_ff       <= total_in;
         idx_ff         <= idx_in;
         off_ff         <= off_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      start_ff     <= start_in;
      red_ff       <= red_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_off_ff   <= rsp_off_in;
      rsp_anim_ff  <= rsp_anim_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         dur_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= dur_mem[rd_addr];
   end

endmodule

// ===== src/afs_checker.sv =====
// ----------------------------------------------------------------------------
// afs_checker
// Port-level checks for the animation frame sequencer, bound to the top.
// ----------------------------------------------------------------------------
module afs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [afs_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import afs_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one transaction at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while busy");

   // clean state after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

endmodule

bind animation_frame_sequencer_unit afs_checker u_afs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== bench/tb_animation_frame_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_animation_frame_sequencer_unit
// Self-checking bench for the animated-image frame sequencer. Load, start,
// tick and no-op transactions are streamed in with random gaps. A local
// model of the delay store, index and offset predicts each result. Every
// result is compared field by field. Frame count and tick length are
// reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_animation_frame_sequencer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import afs_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 500;
   localparam int DRAIN_CYCLES = 300;
   localparam int ITEM_TARGET = 1950;
   localparam int MAX_REPORTS = 40;

   typedef struct packed {
      op_type              op;
      logic [SLOT_W-1:0]   slot;
      logic [RAW_W-1:0]    raw;
      logic [POS_W-1:0]    pos;
   } seq_item_type;

   typedef struct packed {
      logic                animating;
      logic [OFF_W-1:0]    offset;
      logic [FRAME_W-1:0]  frame;
   } frame_view_type;

   logic clock;
   logic reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   logic [DUR_W-1:0]   delay_store [MAX_FRAMES];
   logic [TOTAL_W-1:0] cycle_total = '0;
   logic [FRAME_W-1:0] cur_frame = '0;
   logic [OFF_W-1:0]   cur_offset = '0;
   logic [FC_W-1:0]    cfg_frames = '0;
   logic [TICK_W-1:0]  cfg_tick = TICK_RESET;

   seq_item_type   sequencer_items[$];
   frame_view_type frame_predictions[$];
   seq_item_type   offered;

   int   idle_pct = 36;
   logic rsp_hold = 1'b0;
   int   rsp_count = 0;
   int   mismatches = 0;
   int   stall_cycles = 0;
   int   items_pushed = 0;

   animation_frame_sequencer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Applies one transaction to the local state and returns the view after it.
   function automatic frame_view_type advance_sequencer(seq_item_type it);
      int unsigned active;
      int unsigned total;
      int unsigned off;
      int unsigned idx;
      int unsigned r;
      logic [RAW_W-1:0] d;
      frame_view_type v;
      active = (cfg_frames < MAX_FRAMES) ? cfg_frames : MAX_FRAMES;
      if (it.op == OP_LOAD) begin
         d = it.raw;
         if (d <= SHORT_DELAY) d = DEFAULT_DLY;
         if (d < MIN_DELAY) d = MIN_DELAY;
         delay_store[it.slot] = d;
      end else if ((it.op == OP_START || it.op == OP_TICK) && active > 1) begin
         total = 0;
         for (int i = 0; i < active; i++) total += delay_store[i];
         cycle_total = total[TOTAL_W-1:0];
         if (it.op == OP_START) begin
            cur_frame = '0;
            off = 0;
            if (total != 0) begin
               r = it.pos % total;
               off = (r < START_CAP) ? r : START_CAP;
            end
         end else begin
            off = cur_offset + cfg_tick;
         end
         idx = cur_frame % active;
         if (total == 0) off = 0;
         else if (off > total) off = ((off - 1) % total) + 1;
         while (off > delay_store[idx]) begin
            off -= delay_store[idx];
            idx = (idx + 1) % active;
         end
         cur_frame = idx[FRAME_W-1:0];
         cur_offset = off[OFF_W-1:0];
      end else if (it.op == OP_START) begin
         cur_frame = '0;
         cur_offset = '0;
      end
      v.frame = cur_frame;
      v.offset = cur_offset;
      v.animating = (cfg_frames > 1);
      return v;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatches < MAX_REPORTS) $display("result %0d: %s", rsp_count, msg);
      mismatches++;
   endtask

   task automatic push_item(op_type op, int unsigned slot, int unsigned raw,
                            logic [POS_W-1:0] pos);
      seq_item_type it;
      it.op = op;
      it.slot = slot[SLOT_W-1:0];
      it.raw = raw[RAW_W-1:0];
      it.pos = pos;
      sequencer_items = {sequencer_items, it};
      items_pushed++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (sequencer_items.size() != 0 || req_tvalid || frame_predictions.size() != 0);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int unsigned val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      if (idx == REG_FRAME_COUNT) cfg_frames = val[FC_W-1:0];
      else cfg_tick = val[TICK_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic int unsigned pick_delay(int scale);
      case ($urandom_range(9))
         0: return $urandom_range(19);
         1: return $urandom_range(65535);
         default: begin
            if (scale == 0) return $urandom_range(20, 40);
            else if (scale == 1) return $urandom_range(20, 600);
            else return $urandom_range(20, 65535);
         end
      endcase
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            frame_predictions = {frame_predictions, advance_sequencer(offered)};
         end
         if (!req_tvalid || req_tready) begin
            if (sequencer_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
               offered = sequencer_items.pop_front();
               req_tdata <= {{(REQ_DATA_W - SLOT_W - RAW_W - POS_W){1'b0}},
                             offered.pos, offered.raw, offered.slot};
               req_tuser <= offered.op;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      frame_view_type got;
      frame_view_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (frame_predictions.size() == 0) begin
               report_mismatch("result with no transaction outstanding");
            end else begin
               want = frame_predictions.pop_front();
               if (got.frame !== want.frame)
                  report_mismatch($sformatf("shown_frame %0d, want %0d",
                                            got.frame, want.frame));
               if (got.offset !== want.offset)
                  report_mismatch($sformatf("frame_offset %0d, want %0d",
                                            got.offset, want.offset));
               if (got.animating !== want.animating)
                  report_mismatch($sformatf("animating %0b, want %0b",
                                            got.animating, want.animating));
            end
            rsp_count++;
         end
         rsp_tready <= !rsp_hold && ($urandom_range(99) >= idle_pct);
      end
   end

   // long back-pressure while the sender keeps offering
   initial begin
      do @(posedge clock);
      while (!(rsp_count >= 400 && sequencer_items.size() > 8));
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int unsigned fc;
      int unsigned tick;
      int unsigned active;
      int unsigned r;
      int scale;
      int phase;
      int n_items;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // not animating from reset, delay clamping
      push_item(OP_NOP, 0, 0, '0);
      push_item(OP_START, 0, 0, '1);
      push_item(OP_TICK, 0, 0, '0);
      push_item(OP_LOAD, 0, 0, '0);
      push_item(OP_LOAD, 1, 10, '0);
      push_item(OP_LOAD, 2, 11, '0);
      push_item(OP_LOAD, 3, 19, '0);
      push_item(OP_LOAD, 4, 20, '0);
      push_item(OP_LOAD, 5, 65535, '1);
      push_item(OP_LOAD, 63, 21, '0);
      push_item(OP_START, 0, 0, 32'd777);
      push_item(OP_TICK, 0, 0, '0);
      wait_idle();

      write_csr(REG_FRAME_COUNT, 1);
      push_item(OP_START, 0, 0, 32'd12345);
      push_item(OP_TICK, 0, 0, '0);
      push_item(OP_NOP, 0, 0, '0);
      wait_idle();

      // two frames, tick longer than the whole cycle
      write_csr(REG_FRAME_COUNT, 2);
      write_csr(REG_TICK_LENGTH, 1000);
      push_item(OP_START, 0, 0, '1);
      push_item(OP_TICK, 0, 0, '0);
      push_item(OP_START, 0, 0, 32'd150);
      push_item(OP_TICK, 0, 0, '0);
      wait_idle();

      // offset cap at start, frame boundary on a tick
      write_csr(REG_FRAME_COUNT, 6);
      write_csr(REG_TICK_LENGTH, 1);
      push_item(OP_START, 0, 0, 32'd65794);
      push_item(OP_TICK, 0, 0, '0);
      push_item(OP_START, 0, 0, 32'd100);
      push_item(OP_TICK, 0, 0, '0);
      push_item(OP_NOP, 0, 0, '0);
      wait_idle();

      // every slot written before wider frame counts are used
      for (int s = 0; s < MAX_FRAMES; s++) push_item(OP_LOAD, s, pick_delay(1), $urandom);

      phase = 0;
      while (items_pushed < ITEM_TARGET) begin
         wait_idle();
         phase++;
         r = $urandom_range(99);
         if (r < 65) fc = $urandom_range(2, 8);
         else if (r < 80) fc = $urandom_range(9, 63);
         else if (r < 87) fc = MAX_FRAMES;
         else if (r < 93) fc = $urandom_range(65, 127);
         else fc = $urandom_range(0, 1);
         r = $urandom_range(99);
         if (r < 40) tick = $urandom_range(1, 50);
         else if (r < 85) tick = $urandom_range(51, 1000);
         else tick = $urandom_range(1, 1023);
         if (phase == 1) fc = MAX_FRAMES;
         if (phase == 2) begin
            fc = 127;
            tick = 1000;
         end
         if (phase == 3) tick = 1;
         if (phase == 4) tick = 1023;
         write_csr(REG_FRAME_COUNT, fc);
         write_csr(REG_TICK_LENGTH, tick);

         scale = $urandom_range(2);
         n_items = $urandom_range(30, 90);
         if (phase == 8) begin
            idle_pct <= 0;
            n_items = 200;
         end else begin
            idle_pct <= 36;
         end

         active = (fc < MAX_FRAMES) ? fc : MAX_FRAMES;
         if ($urandom_range(1) == 1)
            for (int s = 0; s < active && s < 8; s++)
               push_item(OP_LOAD, s, pick_delay(scale), $urandom);

         for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(99);
            if (r < 45)
               push_item(OP_TICK, $urandom_range(63), $urandom_range(65535), $urandom);
            else if (r < 70)
               push_item(OP_START, $urandom_range(63), $urandom_range(65535),
                         ($urandom_range(1) == 1) ? $urandom : $urandom_range(3000));
            else if (r < 88)
               push_item(OP_LOAD, $urandom_range(63), pick_delay(scale), $urandom);
            else
               push_item(OP_NOP, $urandom_range(63), $urandom_range(65535), $urandom);
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
